// File: rtl/core/spph_pkg.sv
// Shared constants and types of the spectral peak picker.
package spph_pkg;

  localparam int unsigned BIN_W  = 11;
  localparam int unsigned MAG_W  = 24;
  localparam int unsigned TOL_W  = 6;
  localparam int unsigned MULT_W = 15;  // covers a multiple up to 8192/2 plus one bin step
  localparam logic [BIN_W-1:0] BIN_MAX = 11'd2047;

  localparam logic [0:0] REG_MIN_DISTANCE = 1'b0;
  localparam logic [0:0] REG_HARM_TOL     = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [BIN_W-1:0]  fund;
    logic [MULT_W-1:0] mult;
  } spph_cell_t;

  typedef struct packed {
    logic             adv_en;
    logic             shift_en;
    logic             clear;
    logic [BIN_W-1:0] probe;
    logic [TOL_W-1:0] tol;
  } spph_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_CHECK = 2'b10
  } spph_state_e;

endpackage

// File: rtl/core/spectral_peak_picker_harmonic_reject.sv
// Spectral peak picker with harmonic rejection, top level.
// Bins stream in one per beat. While a detected peak is checked the input is held off; S is
// the largest number of multiple steps any stored fundamental must advance to reach the
// probe bin; the row of MAX_KEPT cells steps all fundamentals in parallel, one multiple per
// cycle. Over a frame S sums to at most FFT_SIZE/2 - 2 per fundamental. Kept peaks enter the
// row at its head while it has room. A result beat is emitted for each kept peak and always
// for the last bin.
module spectral_peak_picker_harmonic_reject #(
  parameter int unsigned FFT_SIZE = 2048,
  parameter int unsigned MAX_KEPT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_addr_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [23:0] magnitude
  input  logic        s_axis_tlast_i,   // last_bin
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [10:0] peak_bin, zero fill above
  output logic [1:0]  m_axis_tuser_o,   // [0] peak_valid, [1] list_overflow
  output logic        m_axis_tlast_o    // frame_end
);
  import spph_pkg::*;

  localparam int unsigned HALF  = FFT_SIZE / 2;
  localparam int unsigned CNT_W = $clog2(MAX_KEPT + 1);

  spph_state_e       state_q, state_d;
  logic [BIN_W-1:0]  min_dist_q;
  logic [TOL_W-1:0]  tol_q;
  logic [BIN_W-1:0]  bin_cnt_q, last_det_q, cand_q;
  logic [MAG_W-1:0]  prev_q, older_q;
  logic              det_any_q, ovf_q, last_q;
  logic [CNT_W-1:0]  kept_cnt_q;
  logic              ovalid_q, opeak_q, oovf_q, olast_q;
  logic [BIN_W-1:0]  obin_q;

  spph_ctrl_t        ctrl;
  spph_cell_t        chain [MAX_KEPT+1];
  logic [MAX_KEPT-1:0] settled, near;

  logic accept, is_peak, too_close, detect, all_settled, check_done, hit, kept, full;
  logic [BIN_W-1:0] cand;

  assign s_axis_tready_o = (state_q == ST_IDLE) && (!ovalid_q || m_axis_tready_i);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  assign cand      = bin_cnt_q - BIN_W'(1);
  assign is_peak   = (bin_cnt_q >= BIN_W'(2)) && (prev_q > older_q) && (prev_q > s_axis_tdata_i);
  assign too_close = det_any_q && ((cand - last_det_q) < min_dist_q);
  assign detect    = is_peak && !too_close;

  assign all_settled = &settled;
  assign check_done  = (state_q == ST_CHECK) && all_settled;
  assign hit         = |near;
  assign kept        = check_done && !hit;
  assign full        = kept_cnt_q == CNT_W'(MAX_KEPT);

  assign ctrl.adv_en   = (state_q == ST_CHECK);
  assign ctrl.shift_en = kept && !full;
  assign ctrl.clear    = (check_done && last_q)
                      || (accept && !detect && s_axis_tlast_i);
  assign ctrl.probe    = cand_q;
  assign ctrl.tol      = tol_q;

  // new fundamental enters at the head; first multiple checked is twice the bin
  assign chain[0].valid = 1'b1;
  assign chain[0].fund  = cand_q;
  assign chain[0].mult  = MULT_W'({cand_q, 1'b0});

  for (genvar g = 0; g < MAX_KEPT; g++) begin : g_cell
    spph_cell #(.HALF(HALF)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .cell_i    (chain[g]),
      .cell_o    (chain[g+1]),
      .settled_o (settled[g]),
      .near_o    (near[g])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && detect) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (all_settled) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      min_dist_q <= BIN_W'(1);
      tol_q      <= TOL_W'(6);
      bin_cnt_q  <= '0;
      prev_q     <= '0;
      older_q    <= '0;
      last_det_q <= '0;
      det_any_q  <= 1'b0;
      kept_cnt_q <= '0;
      ovf_q      <= 1'b0;
      last_q     <= 1'b0;
      cand_q     <= '0;
      ovalid_q   <= 1'b0;
      opeak_q    <= 1'b0;
      obin_q     <= '0;
      olast_q    <= 1'b0;
      oovf_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_MIN_DISTANCE: min_dist_q <= cfg_wdata_i;
          REG_HARM_TOL:     tol_q      <= cfg_wdata_i[TOL_W-1:0];
          default: ;
        endcase
      end

      if ((accept && !detect && s_axis_tlast_i) || (check_done && (kept || last_q))) begin
        ovalid_q <= 1'b1;
      end else if (ovalid_q && m_axis_tready_i) begin
        ovalid_q <= 1'b0;
      end

      if (accept) begin
        last_q <= s_axis_tlast_i;
        cand_q <= cand;
        if (!detect && s_axis_tlast_i) begin
          opeak_q    <= 1'b0;
          obin_q     <= '0;
          olast_q    <= 1'b1;
          oovf_q     <= ovf_q;
          bin_cnt_q  <= '0;
          prev_q     <= '0;
          older_q    <= '0;
          last_det_q <= '0;
          det_any_q  <= 1'b0;
          kept_cnt_q <= '0;
          ovf_q      <= 1'b0;
        end else begin
          older_q <= prev_q;
          prev_q  <= s_axis_tdata_i;
          if (bin_cnt_q < BIN_MAX) bin_cnt_q <= bin_cnt_q + BIN_W'(1);
          if (detect) begin
            det_any_q  <= 1'b1;
            last_det_q <= cand;
          end
        end
      end else if (check_done) begin
        if (kept || last_q) begin
          opeak_q  <= kept;
          obin_q   <= kept ? cand_q : '0;
          olast_q  <= last_q;
          oovf_q   <= ovf_q || (kept && full);
        end
        if (last_q) begin
          bin_cnt_q  <= '0;
          prev_q     <= '0;
          older_q    <= '0;
          last_det_q <= '0;
          det_any_q  <= 1'b0;
          kept_cnt_q <= '0;
          ovf_q      <= 1'b0;
        end else if (kept) begin
          if (full) ovf_q <= 1'b1;
          else      kept_cnt_q <= kept_cnt_q + CNT_W'(1);
        end
      end
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = 16'(obin_q);
  assign m_axis_tuser_o  = {oovf_q, opeak_q};
  assign m_axis_tlast_o  = olast_q;

  // no input beat is taken while a peak is being checked
  a_no_accept_in_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK) |-> !s_axis_tready_o) else $error("accept during check");
  // store count never passes its depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_cnt_q <= CNT_W'(MAX_KEPT)) else $error("kept count overflow");
  // overflow flag is only set with a full store
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> full) else $error("overflow without full store");
  // output slot is free whenever a check runs
  a_check_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK) |-> !ovalid_q) else $error("output busy in check");

endmodule

// File: rtl/core/spph_cell.sv
// One fundamental store cell: holds a fundamental and walks its multiples up to the probe bin.
module spph_cell #(
  parameter int unsigned HALF = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spph_pkg::spph_ctrl_t ctrl_i,
  input  spph_pkg::spph_cell_t cell_i,
  output spph_pkg::spph_cell_t cell_o,
  output logic                settled_o,
  output logic                near_o
);
  import spph_pkg::*;

  logic              valid_q, valid_d;
  logic [BIN_W-1:0]  fund_q, fund_d;
  logic [MULT_W-1:0] mult_q, mult_d;
  logic [MULT_W-1:0] probe_x, tol_x, fund_x, half_x, diff;
  logic              behind, room;

  assign probe_x = MULT_W'(ctrl_i.probe);
  assign tol_x   = MULT_W'(ctrl_i.tol);
  assign fund_x  = MULT_W'(fund_q);
  assign half_x  = MULT_W'(HALF);

  // multiple lies at least tol below the probe and a next multiple still fits
  assign behind = (mult_q + tol_x) <= probe_x;
  assign room   = (mult_q + fund_x) <= half_x;
  assign diff   = (probe_x >= mult_q) ? (probe_x - mult_q) : (mult_q - probe_x);

  assign settled_o = !valid_q || !(behind && room);
  assign near_o    = valid_q && (mult_q <= half_x) && (diff < tol_x);

  always_comb begin
    valid_d = valid_q;
    fund_d  = fund_q;
    mult_d  = mult_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.shift_en) begin
      valid_d = cell_i.valid;
      fund_d  = cell_i.fund;
      mult_d  = cell_i.mult;
    end else if (ctrl_i.adv_en && valid_q && behind && room) begin
      mult_d = mult_q + fund_x;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fund_q <= fund_d;
    mult_q <= mult_d;
  end

  assign cell_o.valid = valid_q;
  assign cell_o.fund  = fund_q;
  assign cell_o.mult  = mult_q;

endmodule

// File: sim/spph_checker.sv
// Checker for the spectral peak picker: follows the bin and result streams, predicts the peaks.
`timescale 1ns / 1ps
module spph_checker #(
  parameter int unsigned FFT_SIZE = 2048,
  parameter int unsigned MAX_KEPT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_addr_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,
  input  logic        s_axis_tlast_i,
  input  logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  input  logic [15:0] m_axis_tdata_o,
  input  logic [1:0]  m_axis_tuser_o,
  input  logic        m_axis_tlast_o,
  output int          err_cnt_o,
  output int          pending_o,
  output int          peaks_o,
  output int          frames_o
);
  import spph_pkg::*;

  typedef struct packed {
    logic             peak_valid;
    logic [BIN_W-1:0] peak_bin;
    logic             frame_end;
    logic             overflow;
  } peak_rpt_t;

  logic [BIN_W-1:0] min_dist;
  logic [TOL_W-1:0] harm_tol;
  logic [BIN_W-1:0] bin_cnt;
  logic [MAG_W-1:0] mag_prev, mag_older;
  logic [BIN_W-1:0] last_det;
  logic             det_any;
  logic [BIN_W-1:0] fund_q[$];
  logic             ovf_seen;
  peak_rpt_t        peak_q[$];

  // Any allowed multiple k (2..FFT_SIZE/(2f)) of a stored fundamental within tolerance.
  function automatic bit near_harmonic(int p);
    int f, hi;
    foreach (fund_q[n]) begin
      f = fund_q[n];
      if (f < 1) continue;
      hi = FFT_SIZE / (2 * f);
      for (int k = 2; k <= hi; k++) begin
        int d;
        d = p - k * f;
        if (d < 0) d = -d;
        if (d < harm_tol) return 1;
      end
    end
    return 0;
  endfunction

  task automatic predict_bin(logic [MAG_W-1:0] mag, logic last);
    peak_rpt_t r;
    int        cand;
    bit        kept;
    kept = 0;
    cand = 0;
    if (bin_cnt >= 2) begin
      cand = bin_cnt - 1;
      if (mag_prev > mag_older && mag_prev > mag) begin
        if (!(det_any && (cand - last_det) < min_dist)) begin
          det_any  = 1;
          last_det = cand[BIN_W-1:0];
          if (!near_harmonic(cand)) begin
            kept = 1;
            if (fund_q.size() < MAX_KEPT) fund_q = {fund_q, cand[BIN_W-1:0]};
            else ovf_seen = 1;
          end
        end
      end
    end
    mag_older = mag_prev;
    mag_prev  = mag;
    if (bin_cnt < BIN_MAX) bin_cnt++;
    if (kept || last) begin
      r.peak_valid = kept;
      r.peak_bin   = kept ? cand[BIN_W-1:0] : '0;
      r.frame_end  = last;
      r.overflow   = ovf_seen;
      peak_q = {peak_q, r};
    end
    if (last) begin
      bin_cnt = '0; mag_prev = '0; mag_older = '0; last_det = '0;
      det_any = 0; fund_q.delete(); ovf_seen = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    peak_rpt_t got, want;
    if (!rst_ni) begin
      min_dist = 11'd1; harm_tol = 6'd6;
      bin_cnt = '0; mag_prev = '0; mag_older = '0; last_det = '0;
      det_any = 0; fund_q.delete(); ovf_seen = 0; peak_q.delete();
      err_cnt_o = 0; peaks_o = 0; frames_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == REG_MIN_DISTANCE) min_dist = cfg_wdata_i;
        else if (cfg_addr_i == REG_HARM_TOL) harm_tol = cfg_wdata_i[TOL_W-1:0];
      end
      if (s_axis_tvalid_i && s_axis_tready_o) predict_bin(s_axis_tdata_i, s_axis_tlast_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = '{m_axis_tuser_o[0], m_axis_tdata_o[BIN_W-1:0], m_axis_tlast_o,
                m_axis_tuser_o[1]};
        if (got.peak_valid) peaks_o++;
        if (got.frame_end) frames_o++;
        if (peak_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %p", $time, got);
          err_cnt_o++;
        end else begin
          want = peak_q.pop_front();
          if (got !== want || m_axis_tdata_o[15:BIN_W] !== '0) begin
            $display("%0t: expected %p, actual %p (tdata %h)", $time, want, got,
                     m_axis_tdata_o);
            err_cnt_o++;
          end
        end
      end
    end
    pending_o = peak_q.size();
  end

endmodule

// File: sim/tb_spectral_peak_picker_harmonic_reject.sv
// Testbench top: drives spectrum frames and configuration, reports the verdict.
`timescale 1ns / 1ps
module tb_spectral_peak_picker_harmonic_reject;
  import spph_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [0:0]  cfg_addr_i = REG_MIN_DISTANCE;
  logic [10:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;
  logic        s_axis_tlast_i = 0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 0;
  logic [15:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;
  int          err_cnt, pending, peaks, frames;
  int          bins_sent;
  bit          no_idle;

  always #1 clk_i = ~clk_i;

  spectral_peak_picker_harmonic_reject u_dut (.*);

  spph_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tlast_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o,
    .m_axis_tlast_o, .err_cnt_o(err_cnt), .pending_o(pending), .peaks_o(peaks),
    .frames_o(frames)
  );

  // Result side stalls at random except during the quiet stretch.
  always @(posedge clk_i) begin
    m_axis_tready_i <= no_idle || ($urandom_range(99) >= 29);
  end

  // tvalid stays up across back-to-back beats; it drops only on an idle cycle
  task automatic send_bin(logic [23:0] mag, logic last);
    while (!no_idle && $urandom_range(99) < 29) begin
      s_axis_tvalid_i <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1;
    s_axis_tdata_i  <= mag;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    bins_sent++;
  endtask

  task automatic write_reg(logic [0:0] idx, logic [10:0] val);
    s_axis_tvalid_i <= 0;
    @(posedge clk_i);
    while (pending != 0 || !s_axis_tready_o) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  // Frame of len bins; peaky frames alternate high and low bins.
  task automatic send_frame(int len, int style);
    logic [23:0] m;
    for (int i = 0; i < len; i++) begin
      case (style)
        0: m = 24'($urandom);
        1: m = (i % 2) ? 24'($urandom_range(1000)) : 24'(24'hFFF000 + $urandom_range(4095));
        default: m = ($urandom_range(2) == 0) ? 24'hFFFFFF : 24'($urandom_range(3));
      endcase
      send_bin(m, i == len - 1);
    end
  endtask

  initial begin
    #200000000;
    $display("spectral_peak_picker_harmonic_reject: mismatch");
    $finish;
  end

  initial begin
    int seg;
    bins_sent = 0;
    no_idle = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: single and two-bin frames, extremes, a clean peak confirmed by the last bin
    send_bin(24'hFFFFFF, 1);
    send_bin(24'h0, 0); send_bin(24'hFFFFFF, 1);
    send_bin(24'h0, 0); send_bin(24'hFFFFFF, 0); send_bin(24'h0, 0);
    send_bin(24'h555555, 0); send_bin(24'hAAAAAA, 0); send_bin(24'h000001, 1);
    // harmonics of bin 2 with tolerance 0 and 63, plateau and equal neighbors
    write_reg(REG_HARM_TOL, 11'd0);
    send_frame(12, 1);
    write_reg(REG_HARM_TOL, 11'd63);
    send_bin(24'd5, 0); send_bin(24'd5, 0); send_bin(24'd9, 0); send_bin(24'd9, 0);
    send_bin(24'd1, 0); send_bin(24'd7, 0); send_bin(24'd2, 1);
    // random phases across settings
    for (seg = 0; bins_sent < 1900; seg++) begin
      no_idle = (seg % 4 == 3);
      case (seg % 6)
        0: write_reg(REG_MIN_DISTANCE, 11'd1024);
        1: write_reg(REG_MIN_DISTANCE, 11'd0);
        2: write_reg(REG_MIN_DISTANCE, 11'($urandom_range(8)));
        3: write_reg(REG_HARM_TOL, 11'($urandom_range(63)));
        4: write_reg(REG_HARM_TOL, 11'd0);
        default: write_reg(REG_MIN_DISTANCE, 11'd1 << $urandom_range(10));
      endcase
      if (seg == 7) begin
        // overlong frame past the bin counter limit, lots of peaks to fill the store
        write_reg(REG_MIN_DISTANCE, 11'd0);
        write_reg(REG_HARM_TOL, 11'd0);
        send_frame(2052, 1);
      end else begin
        send_frame(int'($urandom_range(3, 30)), int'($urandom_range(2)));
      end
    end
    s_axis_tvalid_i <= 0;
    no_idle = 0;
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Sent %0d bins in %0d frames, %0d kept peaks checked.", bins_sent, frames,
             peaks);
    $display("Covered min-distance and tolerance extremes, short and overlong frames.");
    if (err_cnt == 0) begin
      $display("spectral_peak_picker_harmonic_reject: match");
    end else begin
      $display("spectral_peak_picker_harmonic_reject: mismatch");
    end
    $finish;
  end

endmodule
